### hdl/lst_pkg.sv
// Shared types, constants and the aggregate combine function for the
// lazy segment tree block. No dependencies.
package lst_pkg;

    // Tree geometry: LEAVES leaves, padded to a power of two
    localparam int LEAVES   = 1024;
    localparam int LOG_TOP  = $clog2(LEAVES);
    localparam int TOP      = 1 << LOG_TOP;
    localparam int NODE_W   = LOG_TOP + 1;          // node index 1..2*TOP-1
    localparam int LVL_W    = $clog2(LOG_TOP + 1);
    localparam int NODES    = 2 * TOP;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 11;                   // used_count / range fields

    localparam logic [DATA_W-1:0] MIN_IDENT = 32'h7fff_ffff;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    // Configuration register indexes
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_USED = 1'b1;

    typedef enum logic [1:0] {
        CMD_FILL,
        CMD_ASSIGN,
        CMD_QUERY,
        CMD_READ
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_FILL_END,
        ST_VISIT,
        ST_CHECK,
        ST_PUSH0,
        ST_PUSH1,
        ST_PUSH2,
        ST_DECIDE,
        ST_RET,
        ST_POST0,
        ST_POST1,
        ST_POST2,
        ST_DONE
    } state_t;

    // Signed minimum or wrapping sum
    function automatic logic [DATA_W-1:0] combine(input logic sum_mode,
                                                  input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        if (sum_mode)
            r = a + b;
        else if ($signed(a) <= $signed(b))
            r = a;
        else
            r = b;
        return r;
    endfunction

endpackage

### hdl/lazy_segment_tree_assign_query.sv
// Timing: after reset a clearing pass over nodes 1 to 2047 runs before the first
// request is taken. Fill writes one node per cycle.
// Assign, query and point read walk the tree node by node through the
// node memories (one read port and one write port each);
// a typical request visits 20 to 40 nodes. One request at a time.
// Reset: asynchronous active low; mode 0, used_count 1024, tree cleared.
// Lazy segment tree, range assign and range min/sum query, top level.
// Depends on lst_pkg.
module lazy_segment_tree_assign_query
    import lst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // command[1:0], range_low[12:2], range_high[23:13], value[55:24]
    input  logic [55:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // result[31:0]
    output logic [DATA_W-1:0]    m_axis_tdata,
    // is_answer[0]
    output logic                 m_axis_tuser,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    state_t              state_reg, state_next;
    logic                mode_reg;
    logic [CNT_W-1:0]    used_reg;

    cmd_t                cmd_reg, cmd_next;
    logic [CNT_W-1:0]    a_reg, a_next, b_reg, b_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [NODE_W-1:0]   k_reg, k_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   app_reg, app_next;
    logic                after_ret_reg, after_ret_next;
    logic [DATA_W-1:0]   eff_reg, eff_next;
    logic [DATA_W-1:0]   left_reg, left_next;
    logic [NODE_W-1:0]   fill_addr_reg;
    logic [CNT_W-1:0]    fill_cnt_reg, fill_cnt_next;
    logic                fill_wr_reg;
    logic                m_valid_reg;
    logic [DATA_W-1:0]   res_reg;
    logic                ans_reg;

    // Node memories
    logic [DATA_W-1:0]   agg_mem [NODES];
    logic [DATA_W-1:0]   pv_mem  [NODES];
    logic                flag_mem[NODES];
    logic [DATA_W-1:0]   agg_rd, pv_rd;
    logic                flag_rd;
    logic [NODE_W-1:0]   rd_addr;
    logic                agg_we, pv_we, flag_we, flag_wd;
    logic [NODE_W-1:0]   agg_wa, pv_wa, flag_wa;
    logic [DATA_W-1:0]   agg_wd;

    // Node geometry decode
    logic [NODE_W-1:0]   lvl_bit, span;
    logic [LVL_W-1:0]    sh;
    logic [LOG_TOP-1:0]  off, off_sh;
    logic [CNT_W-1:0]    lo, hi;
    logic                leaf, cov, dis;
    logic [NODE_W-1:0]   child;
    logic [DATA_W-1:0]   new_agg, comb_out, fill_prod, fill_wd, ident;
    logic [CNT_W-1:0]    used_sat, cnt_raw;
    logic                accept, is_query, out_free;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign is_query = (cmd_reg == CMD_QUERY) || (cmd_reg == CMD_READ);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign ident    = mode_reg ? '0 : MIN_IDENT;

    assign lvl_bit = NODE_W'(1) << lvl_reg;
    assign sh      = LVL_W'(LOG_TOP) - lvl_reg;
    assign span    = NODE_W'(TOP) >> lvl_reg;
    assign off     = LOG_TOP'(k_reg & ~lvl_bit);
    assign off_sh  = off << sh;
    assign lo      = {1'b0, off_sh} + CNT_W'(1);
    assign hi      = {1'b0, off_sh} + CNT_W'(span);
    assign leaf    = (lvl_reg == LVL_W'(LOG_TOP));
    assign cov     = (lo >= a_reg) && (hi <= b_reg);
    assign dis     = (lo > b_reg) || (hi < a_reg);
    assign child   = {k_reg[NODE_W-2:0], 1'b0};

    // Value a pushed or assigned node takes
    assign new_agg = mode_reg ? (app_reg << sh) : app_reg;

    // Shared combine unit
    assign comb_out = (state_reg == ST_POST2) ? combine(mode_reg, left_reg, agg_rd)
                                              : combine(mode_reg, acc_reg, eff_reg);

    // Fill: real leaf count times value (sum), or value/identity (min)
    assign used_sat = (used_reg > CNT_W'(TOP)) ? CNT_W'(TOP) : used_reg;
    assign cnt_raw  = used_sat - {1'b0, off_sh};
    assign fill_prod = val_reg * {{(DATA_W-CNT_W){1'b0}}, fill_cnt_reg};
    assign fill_wd  = mode_reg ? fill_prod
                               : ((fill_cnt_reg != '0) ? val_reg : MIN_IDENT);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (k_reg == LAST_NODE) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                    state_next = (cmd_t'(s_axis_tdata[1:0]) == CMD_FILL) ? ST_FILL
                                                                         : ST_VISIT;
            end
            ST_FILL:     if (k_reg == LAST_NODE) state_next = ST_FILL_END;
            ST_FILL_END: state_next = ST_DONE;
            ST_VISIT:    state_next = ST_CHECK;
            ST_CHECK:
            begin
                if ((cmd_reg == CMD_ASSIGN && cov) || flag_rd)
                    state_next = ST_PUSH0;
                else
                    state_next = ST_DECIDE;
            end
            ST_PUSH0:
            begin
                if (!leaf)
                    state_next = ST_PUSH1;
                else
                    state_next = after_ret_reg ? ST_RET : ST_DECIDE;
            end
            ST_PUSH1:    state_next = ST_PUSH2;
            ST_PUSH2:    state_next = after_ret_reg ? ST_RET : ST_DECIDE;
            ST_DECIDE:   state_next = (dis || cov) ? ST_RET : ST_VISIT;
            ST_RET:
            begin
                if (k_reg == NODE_W'(1))
                    state_next = ST_DONE;
                else if (!k_reg[0])
                    state_next = ST_VISIT;
                else if (cmd_reg == CMD_ASSIGN)
                    state_next = ST_POST0;
                else
                    state_next = ST_RET;
            end
            ST_POST0:    state_next = ST_POST1;
            ST_POST1:    state_next = ST_POST2;
            ST_POST2:    state_next = ST_RET;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_CLEAR;
        endcase
    end

    // Memory controls and handshake outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        rd_addr = k_reg;
        agg_we  = 1'b0;
        agg_wa  = k_reg;
        agg_wd  = new_agg;
        pv_we   = 1'b0;
        pv_wa   = child;
        flag_we = 1'b0;
        flag_wa = k_reg;
        flag_wd = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                agg_we  = 1'b1;
                agg_wd  = MIN_IDENT;
                flag_we = 1'b1;
            end
            ST_FILL, ST_FILL_END:
            begin
                agg_we  = fill_wr_reg;
                agg_wa  = fill_addr_reg;
                agg_wd  = fill_wd;
                flag_we = fill_wr_reg;
                flag_wa = fill_addr_reg;
            end
            ST_PUSH0:
            begin
                agg_we  = 1'b1;
                flag_we = 1'b1;
                pv_we   = !leaf;
            end
            ST_PUSH1:
            begin
                flag_we = 1'b1;
                flag_wa = child;
                flag_wd = 1'b1;
                pv_we   = 1'b1;
                pv_wa   = child | NODE_W'(1);
            end
            ST_PUSH2:
            begin
                flag_we = 1'b1;
                flag_wa = child | NODE_W'(1);
                flag_wd = 1'b1;
            end
            ST_POST0:    rd_addr = k_reg - NODE_W'(1);
            ST_POST2:
            begin
                agg_we = 1'b1;
                agg_wa = k_reg >> 1;
                agg_wd = comb_out;
            end
            default:     rd_addr = k_reg;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        val_next       = val_reg;
        k_next         = k_reg;
        lvl_next       = lvl_reg;
        acc_next       = acc_reg;
        app_next       = app_reg;
        after_ret_next = after_ret_reg;
        eff_next       = eff_reg;
        left_next      = left_reg;
        fill_cnt_next  = '0;
        case (state_reg)
            ST_CLEAR:    k_next = k_reg + NODE_W'(1);
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd_t'(s_axis_tdata[1:0]);
                    a_next   = s_axis_tdata[12:2];
                    b_next   = (cmd_t'(s_axis_tdata[1:0]) == CMD_READ) ? s_axis_tdata[12:2]
                                                                       : s_axis_tdata[23:13];
                    val_next = s_axis_tdata[55:24];
                    k_next   = NODE_W'(1);
                    lvl_next = '0;
                    acc_next = ident;
                end
            end
            ST_FILL:
            begin
                if (used_sat <= {1'b0, off_sh})
                    fill_cnt_next = '0;
                else if (cnt_raw > CNT_W'(span))
                    fill_cnt_next = CNT_W'(span);
                else
                    fill_cnt_next = cnt_raw;
                k_next = k_reg + NODE_W'(1);
                if ((k_reg + NODE_W'(1)) == (lvl_bit << 1))
                    lvl_next = lvl_reg + LVL_W'(1);
            end
            ST_CHECK:
            begin
                eff_next = agg_rd;
                if (cmd_reg == CMD_ASSIGN && cov)
                begin
                    app_next       = val_reg;
                    after_ret_next = 1'b1;
                end
                else
                begin
                    app_next       = pv_rd;
                    after_ret_next = 1'b0;
                end
            end
            ST_PUSH0:    eff_next = new_agg;
            ST_DECIDE:
            begin
                if (cov)
                    acc_next = comb_out;
                else if (!dis)
                begin
                    k_next   = child;
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
            ST_RET:
            begin
                if (k_reg != NODE_W'(1))
                begin
                    if (!k_reg[0])
                        k_next = k_reg + NODE_W'(1);
                    else if (cmd_reg != CMD_ASSIGN)
                    begin
                        k_next   = k_reg >> 1;
                        lvl_next = lvl_reg - LVL_W'(1);
                    end
                end
            end
            ST_POST1:    left_next = agg_rd;
            ST_POST2:
            begin
                k_next   = k_reg >> 1;
                lvl_next = lvl_reg - LVL_W'(1);
            end
            default:     k_next = k_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            k_reg       <= NODE_W'(1);
            lvl_reg     <= '0;
            mode_reg    <= 1'b0;
            used_reg    <= CNT_W'(1024);
            fill_wr_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            lvl_reg     <= lvl_next;
            fill_wr_reg <= (state_reg == ST_FILL);
            if (cfg_we)
            begin
                if (cfg_index == CFG_MODE)
                    mode_reg <= cfg_data[0];
                else
                    used_reg <= cfg_data;
            end
            if (state_reg == ST_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        val_reg       <= val_next;
        acc_reg       <= acc_next;
        app_reg       <= app_next;
        after_ret_reg <= after_ret_next;
        eff_reg       <= eff_next;
        left_reg      <= left_next;
        fill_addr_reg <= k_reg;
        fill_cnt_reg  <= fill_cnt_next;
        if (state_reg == ST_DONE && out_free)
        begin
            res_reg <= is_query ? acc_reg : '0;
            ans_reg <= is_query;
        end
    end

    // Node memories, registered read
    always_ff @(posedge clk)
    begin
        if (agg_we)
            agg_mem[agg_wa] <= agg_wd;
        agg_rd <= agg_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
            pv_mem[pv_wa] <= app_reg;
        pv_rd <= pv_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
            flag_mem[flag_wa] <= flag_wd;
        flag_rd <= flag_mem[rd_addr];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = res_reg;
    assign m_axis_tuser  = ans_reg;

`ifndef ASSERT_OFF
    // One request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    // Walk pointer stays on the level it claims
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VISIT) |-> ((k_reg >> lvl_reg) == NODE_W'(1)))
        else $error("node index and level disagree");

    // A walk never descends below a leaf
    a_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && leaf) |-> (dis || cov))
        else $error("walk descends below a leaf");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for the lazy segment tree block: a directed table
// and random requests, checked against a behavioral tree model. Needs lst_pkg.
module tb_top;
    import lst_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // command[1:0], range_low[12:2], range_high[23:13], value[55:24]
    logic [55:0]        s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // result[31:0]
    logic [DATA_W-1:0]  m_axis_tdata;
    // is_answer[0]
    logic               m_axis_tuser;
    logic               cfg_we;
    logic               cfg_index;
    logic [CNT_W-1:0]   cfg_data;

    typedef struct packed {
        logic [31:0] result;
        logic        is_answer;
    } answer_t;

    typedef struct {
        cmd_t        cmd;
        logic [10:0] lo;
        logic [10:0] hi;
        logic [31:0] val;
        logic        known;
        logic [31:0] result;
    } row_t;

    lazy_segment_tree_assign_query dut (.*);

    // model copy of the tree and registers
    logic [31:0] agg   [NODES];
    logic [31:0] pend  [NODES];
    logic        pflag [NODES];
    logic        sum_mode;
    int unsigned used_cnt;

    answer_t     expected_q[$];
    int          errors;

    initial begin
        clk = 1'b0;
        forever
        begin
            #10 clk = 1'b1;
            #10 clk = 1'b0;
        end
    end

    function automatic logic [31:0] ident();
        return sum_mode ? 32'd0 : MIN_IDENT;
    endfunction

    function automatic logic [31:0] merge(logic [31:0] a, logic [31:0] b);
        if (sum_mode)
            return a + b;
        return ($signed(a) <= $signed(b)) ? a : b;
    endfunction

    // apply a pending assign to a node and hand it to its children
    function automatic void push_node(int n, int unsigned lo, int unsigned hi);
        logic [31:0] v;
        if (!pflag[n])
            return;
        v = pend[n];
        agg[n] = sum_mode ? v * 32'(hi - lo + 1) : v;
        if (lo != hi)
        begin
            pend[2*n] = v;
            pflag[2*n] = 1'b1;
            pend[2*n+1] = v;
            pflag[2*n+1] = 1'b1;
        end
        pflag[n] = 1'b0;
    endfunction

    function automatic void assign_range(int n, int unsigned lo, int unsigned hi,
                                         int unsigned a, int unsigned b,
                                         logic [31:0] v);
        int unsigned mid;
        push_node(n, lo, hi);
        if (lo > b || hi < a)
            return;
        if (lo >= a && hi <= b)
        begin
            pflag[n] = 1'b1;
            pend[n] = v;
            push_node(n, lo, hi);
            return;
        end
        mid = lo + ((hi - lo) >> 1);
        assign_range(2*n, lo, mid, a, b, v);
        assign_range(2*n+1, mid + 1, hi, a, b, v);
        agg[n] = merge(agg[2*n], agg[2*n+1]);
    endfunction

    function automatic logic [31:0] range_total(int n, int unsigned lo, int unsigned hi,
                                                int unsigned a, int unsigned b);
        int unsigned mid;
        push_node(n, lo, hi);
        if (lo > b || hi < a)
            return ident();
        if (lo >= a && hi <= b)
            return agg[n];
        mid = lo + ((hi - lo) >> 1);
        return merge(range_total(2*n, lo, mid, a, b),
                     range_total(2*n+1, mid + 1, hi, a, b));
    endfunction

    function automatic answer_t tree_step(cmd_t c, int unsigned a, int unsigned b,
                                          logic [31:0] v);
        answer_t r;
        int unsigned n;
        r = '0;
        case (c)
            CMD_FILL:
            begin
                n = (used_cnt > TOP) ? TOP : used_cnt;
                for (int k = 1; k <= TOP; k++)
                    agg[TOP+k-1] = (k <= n) ? v : ident();
                for (int k = TOP - 1; k >= 1; k--)
                    agg[k] = merge(agg[2*k], agg[2*k+1]);
                for (int k = 0; k < NODES; k++)
                begin
                    pend[k] = '0;
                    pflag[k] = 1'b0;
                end
            end
            CMD_ASSIGN:
                assign_range(1, 1, TOP, a, b, v);
            CMD_QUERY:
            begin
                r.result = range_total(1, 1, TOP, a, b);
                r.is_answer = 1'b1;
            end
            default:
            begin
                r.result = range_total(1, 1, TOP, a, a);
                r.is_answer = 1'b1;
            end
        endcase
        return r;
    endfunction

    // drive one request, wait for its acceptance
    task automatic send(cmd_t c, logic [10:0] a, logic [10:0] b, logic [31:0] v,
                        logic known, logic [31:0] want);
        answer_t e;
        e = tree_step(c, a, b, v);
        if (known && e.result !== want)
        begin
            $display("%0t directed row mismatch: table %h model %h", $time, want, e.result);
            errors++;
        end
        expected_q.push_back(e);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, b, a, c};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // random gap between bursts
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        // every result has arrived; then idle for about a fill's length more
        repeat (2200) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CNT_W-1:0] d);
        if (idx == CFG_MODE)
            sum_mode = d[0];
        else
            used_cnt = d;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [10:0] pick_index();
        case ($urandom_range(0, 9))
            0: return 11'd1;
            1: return 11'd1024;
            2: return 11'($urandom_range(1025, 2047));
            3: return 11'd0;
            4, 5: return 11'($urandom_range(1, 40));
            default: return 11'($urandom_range(1, 1024));
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    // receiver stalls in its own on/off pattern
    initial begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 4) == 0)
                m_axis_tready <= 1'b1;
            else if ($urandom_range(0, 2) == 0)
                m_axis_tready <= ~m_axis_tready;
            else
                m_axis_tready <= ($urandom_range(0, 1) == 1);
        end
    end

    // compare results with the model
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result %h/%b", $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                answer_t e;
                e = expected_q.pop_front();
                if (m_axis_tdata !== e.result)
                begin
                    $display("%0t result: expected %h actual %h", $time, e.result, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== e.is_answer)
                begin
                    $display("%0t is_answer: expected %b actual %b",
                             $time, e.is_answer, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        #60000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        row_t dir[$];
        cmd_t c;
        logic [10:0] a;
        logic [10:0] b;
        int n;
        errors = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        sum_mode = 1'b0;
        used_cnt = 1024;
        for (int k = 0; k < NODES; k++)
        begin
            agg[k] = MIN_IDENT;
            pend[k] = '0;
            pflag[k] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset state, extremes, empty and out-of-tree ranges
        dir = '{
            '{CMD_QUERY,  11'd1,    11'd1024, 32'd0,         1'b1, 32'h7fff_ffff},
            '{CMD_READ,   11'd1024, 11'd0,    32'd0,         1'b1, 32'h7fff_ffff},
            '{CMD_ASSIGN, 11'd1,    11'd1024, 32'h8000_0000, 1'b1, 32'd0},
            '{CMD_QUERY,  11'd5,    11'd900,  32'd0,         1'b1, 32'h8000_0000},
            '{CMD_ASSIGN, 11'd3,    11'd7,    32'hffff_ffff, 1'b1, 32'd0},
            '{CMD_READ,   11'd3,    11'd3,    32'd0,         1'b1, 32'hffff_ffff},
            '{CMD_QUERY,  11'd9,    11'd2,    32'd0,         1'b1, 32'h7fff_ffff},
            '{CMD_QUERY,  11'd1025, 11'd2047, 32'd0,         1'b1, 32'h7fff_ffff},
            '{CMD_READ,   11'd0,    11'd0,    32'd0,         1'b1, 32'h7fff_ffff},
            '{CMD_ASSIGN, 11'd2000, 11'd2047, 32'd5,         1'b1, 32'd0},
            '{CMD_ASSIGN, 11'd1000, 11'd2047, 32'h7fff_ffff, 1'b0, 32'd0},
            '{CMD_QUERY,  11'd0,    11'd2047, 32'd0,         1'b0, 32'd0},
            '{CMD_FILL,   11'd0,    11'd0,    32'd42,        1'b1, 32'd0},
            '{CMD_QUERY,  11'd1,    11'd1024, 32'd0,         1'b1, 32'd42},
            '{CMD_READ,   11'd1,    11'd0,    32'd0,         1'b1, 32'd42}
        };
        foreach (dir[i])
            send(dir[i].cmd, dir[i].lo, dir[i].hi, dir[i].val, dir[i].known, dir[i].result);
        drain();

        // sum mode straight over the min tree, then a small fill
        write_reg(CFG_MODE, 11'd1);
        // node over leaves 1..4 still holds the min aggregate
        send(CMD_QUERY, 11'd1, 11'd4, 32'd0, 1'b1, 32'd42);
        drain();
        write_reg(CFG_USED, 11'd3);
        send(CMD_FILL, 11'd0, 11'd0, 32'h7fff_ffff, 1'b0, 32'd0);
        send(CMD_QUERY, 11'd1, 11'd1024, 32'd0, 1'b0, 32'd0);
        send(CMD_ASSIGN, 11'd1, 11'd1024, 32'h8000_0001, 1'b0, 32'd0);
        send(CMD_QUERY, 11'd1, 11'd1024, 32'd0, 1'b0, 32'd0);
        send(CMD_READ, 11'd700, 11'd0, 32'd0, 1'b0, 32'd0);
        drain();

        // random phases across configuration settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_MODE, 11'(ph & 1));
            case (ph)
                0: write_reg(CFG_USED, 11'd1024);
                1: write_reg(CFG_USED, 11'd1);
                2: write_reg(CFG_USED, 11'd0);
                3: write_reg(CFG_USED, 11'd2047);
                default: write_reg(CFG_USED, 11'($urandom_range(0, 2047)));
            endcase
            n = 110;
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 19))
                    0: c = CMD_FILL;
                    1, 2, 3, 4, 5, 6, 7: c = CMD_ASSIGN;
                    8, 9, 10, 11, 12, 13: c = CMD_QUERY;
                    default: c = CMD_READ;
                endcase
                // fills are slow; keep them few
                if (c == CMD_FILL && $urandom_range(0, 2) != 0)
                    c = CMD_ASSIGN;
                a = pick_index();
                b = pick_index();
                if ($urandom_range(0, 4) != 0 && a > b)
                    {a, b} = {b, a};
                send(c, a, b, pick_value(), 1'b0, 32'd0);
            end
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
